@@ hw/rtl/skms_pkg.sv @@
// skms_pkg: shared types and constants for the strobed key matrix scanner
// no dependencies; imported by every module of the block

package skms_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned StrobeW = 3;
  localparam int unsigned RowW    = 4;
  localparam int unsigned ColW    = 3;
  localparam int unsigned KeyCols = 8;
  localparam int unsigned ReadW   = 3;

  // strobe bit positions
  localparam int unsigned StrobeColBit  = 0;
  localparam int unsigned StrobeRowClr  = 1;
  localparam int unsigned StrobeRowStep = 2;

  // read data bit positions
  localparam int unsigned ReadKeyBit  = 1;
  localparam int unsigned ReadTapeBit = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [StrobeW-1:0] strobe_value;
    logic [RowW-1:0]    row_select;
    logic [KeyCols-1:0] key_bits;
    logic               tape_in;
  } item_t;

  typedef struct packed {
    logic [ReadW-1:0] read_data;
    logic             tape_out;
  } result_t;

  // scan position and strobe level handed from the counters to the datapath
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            row_ok;
    logic            tape_level;
    logic            tape_next;
  } scan_status_t;

endpackage

@@ hw/rtl/skms_keymat.sv @@
// skms_keymat: key matrix row storage with load port and single-bit key select
// depends on skms_pkg

module skms_keymat import skms_pkg::*; #(
  parameter int unsigned ROW_COUNT = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [RowW-1:0]    wr_row,
  input  logic [KeyCols-1:0] wr_data,
  input  logic [RowW-1:0]    rd_row,
  input  logic [ColW-1:0]    rd_col,
  output logic               key_bit
);

  localparam int unsigned IdxW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [RowW:0] RowLimit = (RowW+1)'(ROW_COUNT);
  localparam logic [ColW-1:0] ColMax = ColW'(KeyCols - 1);

  logic [KeyCols-1:0] rows [ROW_COUNT];
  logic               wr_ok;
  logic               rd_ok;
  logic [ColW-1:0]    bit_sel;

  assign wr_ok   = ({1'b0, wr_row} < RowLimit);
  assign rd_ok   = ({1'b0, rd_row} < RowLimit);
  assign bit_sel = ColMax - rd_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROW_COUNT; i++) begin
        rows[i] <= '0;
      end
    end else if (wr_en && wr_ok) begin
      rows[wr_row[IdxW-1:0]] <= wr_data;
    end
  end

  always_comb begin
    key_bit = 1'b0;
    if (rd_ok) begin
      key_bit = rows[rd_row[IdxW-1:0]][bit_sel];
    end
  end

endmodule

@@ hw/rtl/skms_scan.sv @@
// skms_scan: strobe register with edge detection, row and column counters
// depends on skms_pkg

module skms_scan import skms_pkg::*; #(
  parameter int unsigned ROW_COUNT = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [CmdW-1:0]    cmd,
  input  logic [StrobeW-1:0] strobe_value,
  output scan_status_t       status
);

  localparam logic [RowW:0] RowLimit = (RowW+1)'(ROW_COUNT);

  logic [StrobeW-1:0] strobe;
  logic [StrobeW-1:0] strobe_next;
  logic [RowW-1:0]    row;
  logic [RowW-1:0]    row_next;
  logic [ColW-1:0]    col;
  logic [ColW-1:0]    col_next;
  logic [RowW-1:0]    row_cleared;
  logic [RowW:0]      row_sum;
  logic               row_ok;

  assign row_ok = ({1'b0, row} < RowLimit);

  always_comb begin
    strobe_next = strobe;
    row_next    = row;
    col_next    = col;
    row_cleared = row;
    row_sum     = '0;
    if (go) begin
      unique case (cmd)
        CMD_WRITE: begin
          // row clear, then column clear, then row step
          if (!strobe[StrobeRowClr] && strobe_value[StrobeRowClr]) begin
            row_cleared = '0;
          end
          row_next = row_cleared;
          if (strobe[StrobeColBit] && !strobe_value[StrobeColBit]) begin
            col_next = '0;
          end
          if (strobe[StrobeRowStep] && !strobe_value[StrobeRowStep]) begin
            row_sum = {1'b0, row_cleared} + (RowW+1)'(1);
            if (row_sum >= RowLimit) begin
              row_sum = row_sum - RowLimit;
            end
            row_next = row_sum[RowW-1:0];
          end
          strobe_next = strobe_value;
        end
        CMD_READ: begin
          if (row_ok) begin
            col_next = col + ColW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= '0;
      row    <= '0;
      col    <= '0;
    end else begin
      strobe <= strobe_next;
      row    <= row_next;
      col    <= col_next;
    end
  end

  assign status.row        = row;
  assign status.col        = col;
  assign status.row_ok     = row_ok;
  assign status.tape_level = strobe[StrobeRowClr];
  assign status.tape_next  = strobe_next[StrobeRowClr];

endmodule

@@ hw/rtl/strobed_key_matrix_scanner_core.sv @@
// strobed_key_matrix_scanner_core: top level, input register, result register
// depends on skms_pkg, skms_scan, skms_keymat

// Serial key matrix scanner. Each transaction on the item channel is one port
// command (strobe write, port read, or key row load) and produces exactly one
// transaction on the result channel. A transaction is captured in the input
// register and then resolved into the result register, and a new transaction
// is accepted every cycle; the only throughput limit is stall on the result
// channel, which propagates back to the item channel once both registers are
// full. The key matrix is held in flip-flops and is cleared by reset.

module strobed_key_matrix_scanner_core import skms_pkg::*; #(
  parameter int unsigned ROW_COUNT = 10
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic         ir_valid;
  item_t        ir;
  logic         ex_go;
  scan_status_t status;
  logic         key_bit;
  logic         load_en;
  result_t      result_next;

  assign ex_go      = ir_valid && (!result_valid || !result_stall);
  assign item_stall = ir_valid && !ex_go;
  assign load_en    = ex_go && (ir.cmd == CMD_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      ir_valid <= 1'b1;
    end else if (ex_go) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      ir <= item;
    end
  end

  skms_scan #(
    .ROW_COUNT (ROW_COUNT)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .go           (ex_go),
    .cmd          (ir.cmd),
    .strobe_value (ir.strobe_value),
    .status       (status)
  );

  skms_keymat #(
    .ROW_COUNT (ROW_COUNT)
  ) u_keymat (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load_en),
    .wr_row  (ir.row_select),
    .wr_data (ir.key_bits),
    .rd_row  (status.row),
    .rd_col  (status.col),
    .key_bit (key_bit)
  );

  always_comb begin
    result_next.read_data = '0;
    result_next.tape_out  = status.tape_next;
    if (ir.cmd == CMD_READ) begin
      result_next.read_data[ReadKeyBit]  = key_bit && status.row_ok;
      result_next.read_data[ReadTapeBit] = ir.tape_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ex_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_go) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (ir_valid && result_valid && result_stall))
    else $error("item stall without both registers full");

  a_non_read_zero: assert property (@(posedge clk) disable iff (rst)
    (ex_go && ir.cmd != CMD_READ) |=> (result.read_data == '0))
    else $error("non-read transaction returned read data");

  a_tape_follows_strobe: assert property (@(posedge clk) disable iff (rst)
    ex_go |=> (result.tape_out == status.tape_level))
    else $error("tape output does not match stored strobe");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    status.row_ok)
    else $error("row counter left its range");
`endif

endmodule
